### src/assert_macros.svh
// Assertion macros shared by the RTL of the double-word divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock, held off while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Check a property on the rising clock, in and out of reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/dwud_pkg.sv
// Package with the shared constants of the double-word unsigned divider.
`timescale 1ns / 1ps
`default_nettype none
package dwud_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int WORD_BITS_MIN = 8;
    localparam int WORD_BITS_MAX = 64;

endpackage
`default_nettype wire

### src/dwud_if.sv
// Item channel interfaces of the double-word unsigned divider.
`timescale 1ns / 1ps
`default_nettype none
interface dwud_in_if #(
    parameter int WORD_BITS = dwud_pkg::WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] dividend_low;
    logic [WORD_BITS-1:0] dividend_high;
    logic [WORD_BITS-1:0] divisor_low;
    logic [WORD_BITS-1:0] divisor_high;

    modport source (
        output valid, dividend_low, dividend_high, divisor_low, divisor_high,
        input  ready
    );
    modport sink (
        input  valid, dividend_low, dividend_high, divisor_low, divisor_high,
        output ready
    );
endinterface

interface dwud_out_if #(
    parameter int WORD_BITS = dwud_pkg::WORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] quotient_low;
    logic [WORD_BITS-1:0] quotient_high;
    logic [WORD_BITS-1:0] remainder_low;
    logic [WORD_BITS-1:0] remainder_high;
    logic                 divide_by_zero;

    modport source (
        output valid, quotient_low, quotient_high, remainder_low, remainder_high,
               divide_by_zero,
        input  ready
    );
    modport sink (
        input  valid, quotient_low, quotient_high, remainder_low, remainder_high,
               divide_by_zero,
        output ready
    );
endinterface
`default_nettype wire

### src/double_word_unsigned_divider.sv
// Throughput: one item per cycle while the skid entry is empty; the 2*WORD_BITS
//   compare-subtract stages, one quotient bit each, let a new item enter every
//   cycle that the pipe is not halted.
// Output register plus one skid entry: input ready is a registered signal.
// Reset (i_rst_n low, synchronous) empties every stage, the output and the skid.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module double_word_unsigned_divider #(
    parameter int WORD_BITS = dwud_pkg::WORD_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dwud_in_if.sink    i_in,
    dwud_out_if.source o_out
);
    import dwud_pkg::*;

    // Double-word width and number of restoring steps (one quotient bit each).
    localparam int DW     = 2 * WORD_BITS;
    localparam int STAGES = DW;

    // ------------------------------------------------------------------
    // Stage registers: partial remainder, dividend bits still to shift in
    // (quotient bits fill from the bottom), divisor and zero-divisor flag.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] r_vld;
    logic [DW-1:0]     r_rem [STAGES];
    logic [DW-1:0]     r_nq  [STAGES];
    logic [DW-1:0]     r_div [STAGES];
    logic [STAGES-1:0] r_dbz;

    // Stage inputs, as seen by each compare-subtract step
    logic [DW-1:0]     s_rem [STAGES];
    logic [DW-1:0]     s_nq  [STAGES];
    logic [DW-1:0]     s_div [STAGES];
    logic [STAGES-1:0] s_dbz;
    logic [STAGES-1:0] s_vld;

    // Step results
    logic [DW-1:0]     n_rem [STAGES];
    logic [DW-1:0]     n_nq  [STAGES];

    // Output register and skid entry
    logic              r_out_valid;
    logic [4*WORD_BITS:0] r_out_data;
    logic              r_skid_valid;
    logic [4*WORD_BITS:0] r_skid_data;

    logic              pipe_en;
    logic              in_take;
    logic              out_take;
    logic              pipe_last;
    logic [4*WORD_BITS:0] pipe_data;

    // The whole pipe moves together; it halts only once the skid entry is
    // occupied, so a waiting result never blocks new items by itself.
    assign pipe_en    = !r_skid_valid;
    assign i_in.ready = pipe_en;
    assign in_take    = i_in.valid && pipe_en;
    assign out_take   = r_out_valid && o_out.ready;

    // Feed stage 0 straight from the input channel.
    assign s_rem[0] = '0;
    assign s_nq[0]  = {i_in.dividend_high, i_in.dividend_low};
    assign s_div[0] = {i_in.divisor_high, i_in.divisor_low};
    assign s_dbz[0] = (i_in.divisor_high == '0) && (i_in.divisor_low == '0);
    assign s_vld[0] = in_take;

    genvar k;
    generate
        for (k = 1; k < STAGES; k++) begin : g_link
            assign s_rem[k] = r_rem[k-1];
            assign s_nq[k]  = r_nq[k-1];
            assign s_div[k] = r_div[k-1];
            assign s_dbz[k] = r_dbz[k-1];
            assign s_vld[k] = r_vld[k-1];
        end

        for (k = 0; k < STAGES; k++) begin : g_step
            logic [DW:0]   shifted;
            logic [DW+1:0] diff;
            logic          ge;

            // Shift the next dividend bit into the remainder, trial-subtract
            // the divisor and keep the difference when it does not borrow.
            // A carry out of the remainder always means the divisor fits.
            always_comb begin
                shifted  = {s_rem[k], s_nq[k][DW-1]};
                diff     = {1'b0, shifted} - {2'b00, s_div[k]};
                ge       = !diff[DW+1];
                n_rem[k] = ge ? diff[DW-1:0] : shifted[DW-1:0];
                n_nq[k]  = {s_nq[k][DW-2:0], ge};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (pipe_en) begin
                    r_vld[k] <= s_vld[k];
                end
            end

            // Payload needs no reset; hold it while the pipe is halted.
            always_ff @(posedge i_clk) begin
                if (pipe_en) begin
                    r_rem[k] <= n_rem[k];
                    r_nq[k]  <= n_nq[k];
                    r_div[k] <= s_div[k];
                    r_dbz[k] <= s_dbz[k];
                end
            end
        end
    endgenerate

    // Leaving the last stage: quotient in r_nq, remainder in r_rem.
    // A zero divisor forces every word to zero.
    assign pipe_last = r_vld[STAGES-1] && pipe_en;
    always_comb begin
        if (r_dbz[STAGES-1]) begin
            pipe_data = {{(4*WORD_BITS){1'b0}}, 1'b1};
        end else begin
            pipe_data = {r_nq[STAGES-1], r_rem[STAGES-1], 1'b0};
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (pipe_last) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (pipe_last) begin
            if (r_out_valid && !out_take) begin
                r_skid_data <= pipe_data;
            end else begin
                r_out_data <= pipe_data;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.quotient_high  = r_out_data[4*WORD_BITS -: WORD_BITS];
    assign o_out.quotient_low   = r_out_data[3*WORD_BITS -: WORD_BITS];
    assign o_out.remainder_high = r_out_data[2*WORD_BITS -: WORD_BITS];
    assign o_out.remainder_low  = r_out_data[WORD_BITS -: WORD_BITS];
    assign o_out.divide_by_zero = r_out_data[0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK_RST(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid entry held with empty output register")
    `ASSERT_CLK_RST(a_stall_to_skid, i_clk, i_rst_n, (pipe_last && r_out_valid && !o_out.ready) |=> r_skid_valid, "item leaving the pipe into a stalled output was dropped")
    `ASSERT_CLK_RST(a_dbz_zero, i_clk, i_rst_n, (o_out.valid && o_out.divide_by_zero) |-> (o_out.quotient_low == '0 && o_out.quotient_high == '0 && o_out.remainder_low == '0 && o_out.remainder_high == '0), "zero divisor gave nonzero words")

endmodule
`default_nettype wire
